>>> hw/rtl/tllbp_pkg.sv
// shared constants and types for the two-level local branch predictor
package tllbp_pkg;

	localparam int INDEX_BITS       = 10;
	localparam int MAX_COUNTER_BITS = 4;
	localparam int ADDR_W           = 32;
	localparam int CFG_W            = 3;
	localparam int TABLE_DEPTH      = 1 << INDEX_BITS;

	localparam logic [CFG_W-1:0] CNT_BITS_RESET = CFG_W'(2);

	typedef logic [INDEX_BITS-1:0]       hist_t;
	typedef logic [MAX_COUNTER_BITS-1:0] ctr_t;
	typedef logic [CFG_W-1:0]            cw_t;
	typedef logic [ADDR_W-1:0]           addr_t;

endpackage

>>> hw/rtl/tllbp_if.sv
// handshake channels of the branch predictor: branch in, prediction out, configuration
interface tllbp_in_if import tllbp_pkg::*; ();
	logic  valid;
	logic  ready;
	addr_t branch_address;
	logic  actual_taken;

	modport source (output valid, branch_address, actual_taken, input ready);
	modport sink (input valid, branch_address, actual_taken, output ready);
endinterface

interface tllbp_out_if;
	logic valid;
	logic ready;
	logic predicted_taken;

	modport source (output valid, predicted_taken, input ready);
	modport sink (input valid, predicted_taken, output ready);
endinterface

interface tllbp_cfg_if import tllbp_pkg::*; ();
	logic valid;
	logic ready;
	cw_t  counter_bits;

	modport source (output valid, counter_bits, input ready);
	modport sink (input valid, counter_bits, output ready);
endinterface

>>> hw/rtl/two_level_local_branch_predictor_unit.sv
// top level of the two-level local history branch predictor
//
//  channel  | dir | payload                              | accepted when
//  ---------+-----+--------------------------------------+------------------------
//  br_in    | in  | branch_address[31:0], actual_taken   | valid && ready
//  br_out   | out | predicted_taken                      | valid && ready
//  cfg      | in  | counter_bits[2:0]                    | valid && ready (always)
//
// one item per cycle unless stage 3 stalls or the rams are clearing
// stage 1 reads the history ram, stage 2 the counter ram, stage 3 holds the result
// after reset both rams are cleared with br_in.ready low
// a held result in stage 3 stalls the whole pipeline
module two_level_local_branch_predictor_unit
	import tllbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tllbp_in_if.sink    br_in,
	tllbp_out_if.source br_out,
	tllbp_cfg_if.sink   cfg
);

	logic  clr_busy_q;
	hist_t clr_idx_q;
	cw_t   counter_bits_q;

	logic  en;
	logic  acc;

	logic  v_s1, v_s2, v_s3;
	hist_t slot_s1, slot_s2;
	logic  taken_s1, taken_s2;
	hist_t hist_s2, hist_s3;
	hist_t hnew_s2;
	ctr_t  ctr_s3;
	logic  pred_s3;

	hist_t lht_rdata;
	ctr_t  pht_rdata;
	hist_t hist_s1;
	hist_t hnew_s1;

	logic  lht_we, pht_we;
	hist_t lht_waddr, pht_waddr;
	hist_t lht_wdata;
	ctr_t  pht_wdata;

	cw_t   width;
	ctr_t  top;
	ctr_t  half;
	ctr_t  ctr_rd;
	ctr_t  ctr_sat;
	ctr_t  ctr_new;
	logic  pred_s2;

	assign en         = !v_s3 || br_out.ready;
	assign br_in.ready = !clr_busy_q && en;
	assign acc        = br_in.valid && br_in.ready;
	assign cfg.ready  = 1'b1;

	assign br_out.valid           = v_s3;
	assign br_out.predicted_taken = pred_s3;

	// history stage
	always_comb begin
		hist_s1 = (v_s2 && slot_s2 == slot_s1) ? hnew_s2 : lht_rdata;
		hnew_s1 = (hist_s1 << 1) | hist_t'(taken_s1);
	end

	// counter stage
	always_comb begin
		priority if (counter_bits_q == cw_t'(0)) begin
			width = cw_t'(1);
		end else if (counter_bits_q > cw_t'(MAX_COUNTER_BITS)) begin
			width = cw_t'(MAX_COUNTER_BITS);
		end else begin
			width = counter_bits_q;
		end
		top     = {MAX_COUNTER_BITS{1'b1}} >> (cw_t'(MAX_COUNTER_BITS) - width);
		half    = (top >> 1) + ctr_t'(1);
		ctr_rd  = (v_s3 && hist_s3 == hist_s2) ? ctr_s3 : pht_rdata;
		ctr_sat = (ctr_rd > top) ? top : ctr_rd;
		pred_s2 = (ctr_sat >= half);
		if (taken_s2) begin
			ctr_new = (ctr_sat < top) ? ctr_sat + ctr_t'(1) : ctr_sat;
		end else begin
			ctr_new = (ctr_sat != ctr_t'(0)) ? ctr_sat - ctr_t'(1) : ctr_sat;
		end
	end

	// ram write ports, shared with the clearing sweep
	always_comb begin
		lht_we    = clr_busy_q || (en && v_s1);
		lht_waddr = clr_busy_q ? clr_idx_q : slot_s1;
		lht_wdata = clr_busy_q ? '0 : hnew_s1;
		pht_we    = clr_busy_q || (en && v_s2);
		pht_waddr = clr_busy_q ? clr_idx_q : hist_s2;
		pht_wdata = clr_busy_q ? '0 : ctr_new;
	end

	tllbp_ram #(
		.WIDTH(INDEX_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_lht (
		.clk  (clk),
		.we   (lht_we),
		.waddr(lht_waddr),
		.wdata(lht_wdata),
		.re   (en),
		.raddr(br_in.branch_address[INDEX_BITS-1:0]),
		.rdata(lht_rdata)
	);

	tllbp_ram #(
		.WIDTH(MAX_COUNTER_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_pht (
		.clk  (clk),
		.we   (pht_we),
		.waddr(pht_waddr),
		.wdata(pht_wdata),
		.re   (en),
		.raddr(hist_s1),
		.rdata(pht_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q     <= 1'b1;
			clr_idx_q      <= '0;
			counter_bits_q <= CNT_BITS_RESET;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + hist_t'(1);
				if (clr_idx_q == {INDEX_BITS{1'b1}}) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg.valid) begin
				counter_bits_q <= cfg.counter_bits;
			end
			if (en) begin
				v_s1 <= acc;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1  <= br_in.branch_address[INDEX_BITS-1:0];
			taken_s1 <= br_in.actual_taken;
			slot_s2  <= slot_s1;
			taken_s2 <= taken_s1;
			hist_s2  <= hist_s1;
			hnew_s2  <= hnew_s1;
			hist_s3  <= hist_s2;
			ctr_s3   <= ctr_new;
			pred_s3  <= pred_s2;
		end
	end

endmodule

>>> hw/rtl/tllbp_ram.sv
// generic single write port, single read port ram with registered read
module tllbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tllbp_checker.sv
// port-level checks on the branch predictor, bound to the top level
module tllbp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_pred
);

	// a held prediction keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pred))
		else $error("prediction changed while held");

	// a held prediction stalls the input side
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// an accepted item shows up as a valid prediction when the output does not stall in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (!out_valid || out_ready)
		##1 (!out_valid || out_ready) |=> out_valid)
		else $error("prediction missing after three cycles");

	// table clearing blocks input right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready && !out_valid)
		else $error("input ready before tables cleared");

endmodule

bind two_level_local_branch_predictor_unit tllbp_checker u_tllbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (br_in.valid),
	.in_ready (br_in.ready),
	.out_valid(br_out.valid),
	.out_ready(br_out.ready),
	.out_pred (br_out.predicted_taken)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench for the two-level local history branch predictor: directed, random and backpressure
module testbench;
	import tllbp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int LOOP_COUNT  = 8;
	localparam int MAX_PRINTS  = 30;

	typedef struct {
		addr_t address;
		logic  taken;
	} forecast_t;

	logic clk = 1'b0;
	logic arst_n;
	logic rx_hold = 1'b0;

	tllbp_in_if  br_in_ch ();
	tllbp_out_if br_out_ch ();
	tllbp_cfg_if cfg_ch ();

	two_level_local_branch_predictor_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.br_in  (br_in_ch),
		.br_out (br_out_ch),
		.cfg    (cfg_ch)
	);

	hist_t hist_mem [TABLE_DEPTH];
	ctr_t  ctr_mem [TABLE_DEPTH];
	cw_t   model_width;

	forecast_t forecasts_due [$];
	forecast_t due;

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int sent_count;
	int checked_count;
	int width_writes;

	addr_t loop_addr [LOOP_COUNT];
	int    loop_len [LOOP_COUNT];
	int    loop_pos [LOOP_COUNT];

	event hold_start;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d predictions outstanding", forecasts_due.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic logic predict_and_train(input addr_t address, input logic taken);
		hist_t       slot;
		hist_t       hist;
		int unsigned w;
		int unsigned top;
		int unsigned half;
		int unsigned ctr;
		logic        pred;
		slot = address[INDEX_BITS-1:0];
		hist = hist_mem[slot];
		w = 32'(model_width);
		if (w < 1) w = 1;
		if (w > MAX_COUNTER_BITS) w = MAX_COUNTER_BITS;
		top  = (1 << w) - 1;
		half = 1 << (w - 1);
		ctr  = 32'(ctr_mem[hist]);
		if (ctr > top) ctr = top;
		pred = (ctr >= half);
		if (taken) begin
			if (ctr < top) ctr++;
		end else if (ctr > 0) begin
			ctr--;
		end
		ctr_mem[hist]  = ctr_t'(ctr);
		hist_mem[slot] = {hist[INDEX_BITS-2:0], taken};
		return pred;
	endfunction

	task automatic report_mismatch(input string what, input addr_t address, input logic got,
			input logic want);
		if (error_count < MAX_PRINTS)
			$display("%0t: MISMATCH %s addr %h got %b want %b", $time, what, address, got, want);
		error_count++;
	endtask

	// prediction checker and output stall
	always @(posedge clk) begin
		if (arst_n === 1'b1 && br_out_ch.valid === 1'b1 && br_out_ch.ready === 1'b1) begin
			if (forecasts_due.size() == 0) begin
				report_mismatch("prediction with nothing outstanding", '0,
					br_out_ch.predicted_taken, 1'bx);
			end else begin
				due = forecasts_due.pop_front();
				if (br_out_ch.predicted_taken !== due.taken)
					report_mismatch("predicted_taken", due.address, br_out_ch.predicted_taken,
						due.taken);
				checked_count++;
			end
		end
		br_out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	always begin
		@(hold_start);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_branch(input addr_t address, input logic taken);
		while ($urandom_range(99) < send_idle_pct) begin
			br_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		br_in_ch.valid          <= 1'b1;
		br_in_ch.branch_address <= address;
		br_in_ch.actual_taken   <= taken;
		do @(posedge clk); while (br_in_ch.ready !== 1'b1);
		forecasts_due.push_back('{address, predict_and_train(address, taken)});
		sent_count++;
	endtask

	task automatic drain_predictions();
		br_in_ch.valid <= 1'b0;
		while (forecasts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_counter_bits(input cw_t width);
		drain_predictions();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.counter_bits <= width;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		model_width = width;
		width_writes++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_directed();
		int i;
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h0000_0400, 1'b1);
		send_branch(32'hAAAA_5555, 1'b1);
		send_branch(32'h5555_AAAA, 1'b0);
		// fresh slots with empty history train the shared counter upward
		write_counter_bits(3'd4);
		for (i = 0; i < 12; i++)
			send_branch(32'h0000_0100 + i, 1'b1);
		// stored counters now above the narrower range
		write_counter_bits(3'd1);
		send_branch(32'h0000_0200, 1'b1);
		send_branch(32'h0000_0201, 1'b0);
		// zero width acts as one bit
		write_counter_bits(3'd0);
		send_branch(32'h0000_0202, 1'b0);
		send_branch(32'h0000_0203, 1'b1);
		// oversized width clamps to the maximum
		write_counter_bits(3'd7);
		send_branch(32'h0000_0204, 1'b1);
		send_branch(32'h0000_0205, 1'b0);
		drain_predictions();
	endtask

	task automatic test_random(input int count);
		int    i;
		int    k;
		int    pick;
		addr_t address;
		logic  taken;
		for (k = 0; k < LOOP_COUNT; k++) begin
			loop_addr[k] = $urandom;
			loop_len[k]  = $urandom_range(8, 2);
			loop_pos[k]  = 0;
		end
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			k    = $urandom_range(LOOP_COUNT - 1);
			if (pick < 70) begin
				// loop branch: taken until the last iteration
				address    = loop_addr[k];
				taken      = (loop_pos[k] != loop_len[k] - 1);
				loop_pos[k] = (loop_pos[k] + 1) % loop_len[k];
			end else if (pick < 85) begin
				address = $urandom;
				taken   = 1'($urandom_range(1));
			end else begin
				// different upper bits on a busy slot
				address = $urandom;
				address[INDEX_BITS-1:0] = loop_addr[k][INDEX_BITS-1:0];
				taken = 1'($urandom_range(1));
			end
			send_branch(address, taken);
		end
		drain_predictions();
	endtask

	task automatic test_backpressure();
		int i;
		set_idling(0, 0);
		-> hold_start;
		for (i = 0; i < 40; i++)
			send_branch($urandom, 1'($urandom_range(1)));
		drain_predictions();
	endtask

	initial begin
		arst_n                  = 1'b0;
		br_in_ch.valid          = 1'b0;
		br_in_ch.branch_address = '0;
		br_in_ch.actual_taken   = 1'b0;
		br_out_ch.ready         = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.counter_bits     = '0;
		foreach (hist_mem[i]) hist_mem[i] = '0;
		foreach (ctr_mem[i]) ctr_mem[i] = '0;
		model_width   = CNT_BITS_RESET;
		error_count   = 0;
		sent_count    = 0;
		checked_count = 0;
		width_writes  = 0;
		set_idling(13, 71);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();

		write_counter_bits(3'd3);
		test_random(120);
		write_counter_bits(3'd5);
		test_random(110);

		set_idling(71, 13);
		write_counter_bits(3'd1);
		test_random(110);
		write_counter_bits(3'd6);
		test_random(110);

		set_idling(0, 0);
		write_counter_bits(3'd4);
		test_random(90);
		write_counter_bits(3'd0);
		test_random(60);
		write_counter_bits(3'd2);
		test_random(100);

		test_backpressure();

		drain_predictions();
		repeat (10) @(posedge clk);
		$display("sent %0d branches, checked %0d predictions across %0d width settings",
			sent_count, checked_count, width_writes);
		$display("covered widths 0 to 7, aliased slots, loop patterns and a long output stall");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tllbp_pkg.sv
hw/rtl/tllbp_if.sv
hw/rtl/tllbp_ram.sv
hw/rtl/two_level_local_branch_predictor_unit.sv
hw/rtl/tllbp_checker.sv
verif/testbench.sv
